### rtl/core/glyph_cell_text_renderer_assert.svh
// Assertion macros shared by the checker of the glyph cell text renderer.
// Each macro expects a signal named clk in the scope where it is used, GCTR_ASSERT also rst.
`ifndef GLYPH_CELL_TEXT_RENDERER_ASSERT_SVH
`define GLYPH_CELL_TEXT_RENDERER_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define GCTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define GCTR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/gctr_pkg.sv
// Package of the glyph cell text renderer: bus command codes, character range
// and the 5x7 font table. No dependencies.
`default_nettype none

package gctr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF = 320;

  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

  localparam logic [7:0] CODE_FIRST   = 8'h20;
  localparam logic [7:0] CODE_LAST    = 8'h7E;
  localparam logic [7:0] CODE_REPLACE = 8'h3F;

  localparam logic [15:0] CELL_STEP  = 16'd6;
  localparam logic [15:0] CELL_XSPAN = 16'd5;
  localparam logic [15:0] CELL_YSPAN = 16'd7;

  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned CELL_COLS  = 6;
  localparam int unsigned CELL_ROWS  = 8;

  // Five column bytes of a glyph, leftmost column in the top byte. Bit n of a
  // column byte is pixel row n from the top.
  function automatic logic [39:0] glyph_columns(input logic [6:0] idx);
    logic [39:0] g;
    unique case (idx)
      7'd0:  g = 40'h00_00_00_00_00;
      7'd1:  g = 40'h00_00_5F_00_00;
      7'd2:  g = 40'h00_07_00_07_00;
      7'd3:  g = 40'h14_7F_14_7F_14;
      7'd4:  g = 40'h24_2A_7F_2A_12;
      7'd5:  g = 40'h23_13_08_64_62;
      7'd6:  g = 40'h36_49_55_22_50;
      7'd7:  g = 40'h00_05_03_00_00;
      7'd8:  g = 40'h00_1C_22_41_00;
      7'd9:  g = 40'h00_41_22_1C_00;
      7'd10: g = 40'h14_08_3E_08_14;
      7'd11: g = 40'h08_08_3E_08_08;
      7'd12: g = 40'h00_50_30_00_00;
      7'd13: g = 40'h08_08_08_08_08;
      7'd14: g = 40'h00_60_60_00_00;
      7'd15: g = 40'h20_10_08_04_02;
      7'd16: g = 40'h3E_51_49_45_3E;
      7'd17: g = 40'h00_42_7F_40_00;
      7'd18: g = 40'h42_61_51_49_46;
      7'd19: g = 40'h21_41_45_4B_31;
      7'd20: g = 40'h18_14_12_7F_10;
      7'd21: g = 40'h27_45_45_45_39;
      7'd22: g = 40'h3C_4A_49_49_30;
      7'd23: g = 40'h01_71_09_05_03;
      7'd24: g = 40'h36_49_49_49_36;
      7'd25: g = 40'h06_49_49_29_1E;
      7'd26: g = 40'h00_36_36_00_00;
      7'd27: g = 40'h00_56_36_00_00;
      7'd28: g = 40'h08_14_22_41_00;
      7'd29: g = 40'h14_14_14_14_14;
      7'd30: g = 40'h00_41_22_14_08;
      7'd31: g = 40'h02_01_51_09_06;
      7'd32: g = 40'h32_49_79_41_3E;
      7'd33: g = 40'h7E_11_11_11_7E;
      7'd34: g = 40'h7F_49_49_49_36;
      7'd35: g = 40'h3E_41_41_41_22;
      7'd36: g = 40'h7F_41_41_22_1C;
      7'd37: g = 40'h7F_49_49_49_41;
      7'd38: g = 40'h7F_09_09_09_01;
      7'd39: g = 40'h3E_41_49_49_7A;
      7'd40: g = 40'h7F_08_08_08_7F;
      7'd41: g = 40'h00_41_7F_41_00;
      7'd42: g = 40'h20_40_41_3F_01;
      7'd43: g = 40'h7F_08_14_22_41;
      7'd44: g = 40'h7F_40_40_40_40;
      7'd45: g = 40'h7F_02_0C_02_7F;
      7'd46: g = 40'h7F_04_08_10_7F;
      7'd47: g = 40'h3E_41_41_41_3E;
      7'd48: g = 40'h7F_09_09_09_06;
      7'd49: g = 40'h3E_41_51_21_5E;
      7'd50: g = 40'h7F_09_19_29_46;
      7'd51: g = 40'h46_49_49_49_31;
      7'd52: g = 40'h01_01_7F_01_01;
      7'd53: g = 40'h3F_40_40_40_3F;
      7'd54: g = 40'h1F_20_40_20_1F;
      7'd55: g = 40'h3F_40_38_40_3F;
      7'd56: g = 40'h63_14_08_14_63;
      7'd57: g = 40'h07_08_70_08_07;
      7'd58: g = 40'h61_51_49_45_43;
      7'd59: g = 40'h00_7F_41_41_00;
      7'd60: g = 40'h02_04_08_10_20;
      7'd61: g = 40'h00_41_41_7F_00;
      7'd62: g = 40'h04_02_01_02_04;
      7'd63: g = 40'h40_40_40_40_40;
      7'd64: g = 40'h00_01_02_04_00;
      7'd65: g = 40'h20_54_54_54_78;
      7'd66: g = 40'h7F_48_44_44_38;
      7'd67: g = 40'h38_44_44_44_20;
      7'd68: g = 40'h38_44_44_48_7F;
      7'd69: g = 40'h38_54_54_54_18;
      7'd70: g = 40'h08_7E_09_01_02;
      7'd71: g = 40'h0C_52_52_52_3E;
      7'd72: g = 40'h7F_08_04_04_78;
      7'd73: g = 40'h00_44_7D_40_00;
      7'd74: g = 40'h20_40_44_3D_00;
      7'd75: g = 40'h7F_10_28_44_00;
      7'd76: g = 40'h00_41_7F_40_00;
      7'd77: g = 40'h7C_04_18_04_78;
      7'd78: g = 40'h7C_08_04_04_78;
      7'd79: g = 40'h38_44_44_44_38;
      7'd80: g = 40'h7C_14_14_14_08;
      7'd81: g = 40'h08_14_14_18_7C;
      7'd82: g = 40'h7C_08_04_04_08;
      7'd83: g = 40'h48_54_54_54_20;
      7'd84: g = 40'h04_3F_44_40_20;
      7'd85: g = 40'h3C_40_40_20_7C;
      7'd86: g = 40'h1C_20_40_20_1C;
      7'd87: g = 40'h3C_40_30_40_3C;
      7'd88: g = 40'h44_28_10_28_44;
      7'd89: g = 40'h0C_50_50_50_3C;
      7'd90: g = 40'h44_64_54_4C_44;
      7'd91: g = 40'h00_08_36_41_00;
      7'd92: g = 40'h00_00_7F_00_00;
      7'd93: g = 40'h00_41_36_08_00;
      7'd94: g = 40'h10_08_08_10_08;
      default: g = 40'h00_00_00_00_00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### rtl/core/glyph_cell_text_renderer.sv
// Glyph cell text renderer. A drawn character costs 59 output transfers, one
// per cycle unless m_tready stalls: a column window command with four address
// bytes, a row window command with four address bytes, the memory write
// command and 48 RGB565 pixels of a 6x8 cell, the last one marked by tlast.
// The output register is the limit: the next character is taken in the cycle
// its predecessor's final pixel is loaded, so cells are sent back to back.
// A character that arrives while the string is stopped (past the right edge,
// or before any string start) is taken and yields nothing. The
// glyph is read from a registered font ROM in the cycle the character is
// taken; its pixels are needed eleven transfers later.
// Depends on gctr_pkg.
`default_nettype none

module glyph_cell_text_renderer
  import gctr_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // char_code [7:0], start_x [23:8], start_y [39:24], fg_color [55:40],
  // bg_color [71:56]
  input  logic [71:0] s_tdata,
  // first_of_string [0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // bus_word [15:0]
  output logic [15:0] m_tdata,
  // is_command [0]
  output logic        m_tuser,
  // last_of_char
  output logic        m_tlast
);

  localparam logic [5:0] STEP_COL_CMD = 6'd0;
  localparam logic [5:0] STEP_X0_HI   = 6'd1;
  localparam logic [5:0] STEP_X0_LO   = 6'd2;
  localparam logic [5:0] STEP_X1_HI   = 6'd3;
  localparam logic [5:0] STEP_X1_LO   = 6'd4;
  localparam logic [5:0] STEP_ROW_CMD = 6'd5;
  localparam logic [5:0] STEP_Y0_HI   = 6'd6;
  localparam logic [5:0] STEP_Y0_LO   = 6'd7;
  localparam logic [5:0] STEP_Y1_HI   = 6'd8;
  localparam logic [5:0] STEP_Y1_LO   = 6'd9;
  localparam logic [5:0] STEP_MEM_CMD = 6'd10;
  localparam logic [5:0] STEP_PIX0    = 6'd11;
  localparam logic [5:0] STEP_LAST    = 6'd58;

  localparam logic [2:0] LAST_COL  = 3'(CELL_COLS - 1);
  localparam logic [2:0] GLYPH_END = 3'(GLYPH_COLS);
  localparam logic [2:0] LEFT_COL  = 3'(GLYPH_COLS - 1);

  // String state.
  logic [15:0] cursor_x;
  logic [15:0] line_y;
  logic        stopped;

  // Cell being sent.
  logic        busy;
  logic [5:0]  step;
  logic [2:0]  pix_row;
  logic [2:0]  pix_col;
  logic [15:0] win_x0, win_x1, win_y0, win_y1;
  logic [15:0] fg, bg;
  logic [39:0] glyph_q;

  logic [7:0]  in_code;
  logic [15:0] eff_x, eff_y, nx;
  logic        eff_stop, stop_next, code_ok;
  logic [6:0]  glyph_idx;
  logic        accept, draw, load, last_step;

  logic [2:0]  rev_col;
  logic        pix_on;
  logic        word_cmd, word_last;
  logic [15:0] word_data;

  assign in_code   = s_tdata[7:0];
  assign eff_x     = s_tuser ? s_tdata[23:8]  : cursor_x;
  assign eff_y     = s_tuser ? s_tdata[39:24] : line_y;
  assign eff_stop  = s_tuser ? 1'b0 : stopped;
  assign nx        = eff_x + CELL_STEP;
  assign stop_next = ({1'b0, nx} + {1'b0, CELL_STEP}) > 17'(SCREEN_WIDTH);
  assign code_ok   = (in_code >= CODE_FIRST) && (in_code <= CODE_LAST);
  assign glyph_idx = code_ok ? 7'(in_code - CODE_FIRST) : 7'(CODE_REPLACE - CODE_FIRST);

  assign load      = busy && (!m_tvalid || m_tready);
  assign last_step = (step == STEP_LAST);
  assign s_tready  = !busy || (load && last_step);
  assign accept    = s_tvalid && s_tready;
  assign draw      = accept && !eff_stop;

  // Glyph bytes hold the leftmost column on top, so the bit index is the
  // mirrored column number over the row number.
  assign rev_col = (pix_col < GLYPH_END) ? (LEFT_COL - pix_col) : 3'd0;
  assign pix_on  = (pix_col < GLYPH_END) && glyph_q[{rev_col, pix_row}];

  always_comb begin
    word_cmd  = 1'b0;
    word_last = 1'b0;
    word_data = 16'h0000;
    unique case (step)
      STEP_COL_CMD: begin
        word_cmd  = 1'b1;
        word_data = {8'h00, CMD_COLUMN_SET};
      end
      STEP_X0_HI: word_data = {8'h00, win_x0[15:8]};
      STEP_X0_LO: word_data = {8'h00, win_x0[7:0]};
      STEP_X1_HI: word_data = {8'h00, win_x1[15:8]};
      STEP_X1_LO: word_data = {8'h00, win_x1[7:0]};
      STEP_ROW_CMD: begin
        word_cmd  = 1'b1;
        word_data = {8'h00, CMD_ROW_SET};
      end
      STEP_Y0_HI: word_data = {8'h00, win_y0[15:8]};
      STEP_Y0_LO: word_data = {8'h00, win_y0[7:0]};
      STEP_Y1_HI: word_data = {8'h00, win_y1[15:8]};
      STEP_Y1_LO: word_data = {8'h00, win_y1[7:0]};
      STEP_MEM_CMD: begin
        word_cmd  = 1'b1;
        word_data = {8'h00, CMD_MEM_WRITE};
      end
      default: begin
        word_data = pix_on ? fg : bg;
        word_last = last_step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= 16'h0000;
      line_y   <= 16'h0000;
      stopped  <= 1'b1;
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (draw) begin
        cursor_x <= nx;
        line_y   <= eff_y;
        stopped  <= stop_next;
      end
      if (draw) begin
        busy <= 1'b1;
      end else if (load && last_step) begin
        busy <= 1'b0;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      step    <= STEP_COL_CMD;
      pix_row <= 3'd0;
      pix_col <= 3'd0;
      win_x0  <= eff_x;
      win_x1  <= eff_x + CELL_XSPAN;
      win_y0  <= eff_y;
      win_y1  <= eff_y + CELL_YSPAN;
      fg      <= s_tdata[55:40];
      bg      <= s_tdata[71:56];
      glyph_q <= glyph_columns(glyph_idx);
    end else if (load) begin
      step <= step + 6'd1;
      if (step >= STEP_PIX0) begin
        if (pix_col == LAST_COL) begin
          pix_col <= 3'd0;
          pix_row <= pix_row + 3'd1;
        end else begin
          pix_col <= pix_col + 3'd1;
        end
      end
    end
    if (load) begin
      m_tdata <= word_data;
      m_tuser <= word_cmd;
      m_tlast <= word_last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/gctr_checker.sv
// Port-level checker for the glyph cell text renderer, bound to glyph_cell_text_renderer.
// Depends on gctr_pkg and glyph_cell_text_renderer_assert.svh.
`default_nettype none

`include "glyph_cell_text_renderer_assert.svh"

module gctr_checker
  import gctr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  logic        mem_cmd_xfer;
  logic        out_stall;
  logic [17:0] out_word;

  assign mem_cmd_xfer = m_tvalid && m_tready && m_tuser && (m_tdata[7:0] == CMD_MEM_WRITE);
  assign out_stall    = m_tvalid && !m_tready;
  assign out_word     = {m_tdata, m_tuser, m_tlast};

  // Nothing is offered in the cycle after reset.
  `GCTR_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

  // The end of a cell is always a pixel, never a command.
  `GCTR_ASSERT(a_last_is_pixel, m_tvalid && m_tlast |-> !m_tuser, "tlast on a command")

  // The memory write command is followed at once by the first pixel.
  `GCTR_ASSERT(a_pixels_follow, mem_cmd_xfer |=> m_tvalid && !m_tuser, "no pixel after memory write")

  // A stalled transfer keeps its contents.
  `GCTR_ASSERT(a_stall_holds, out_stall |=> m_tvalid && $stable(out_word), "output changed while stalled")

endmodule

bind glyph_cell_text_renderer gctr_checker u_gctr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/glyph_cell_text_renderer_tb.sv
// Self-checking testbench of the glyph cell text renderer: directed strings, then
// random strings under three sender and receiver stall mixes.
// Depends on gctr_pkg and glyph_cell_text_renderer.
`default_nettype none

module glyph_cell_text_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gctr_pkg::*;

  localparam int SCREEN_W       = 320;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int REPORT_LIMIT   = 10;
  localparam int ITEM_TARGET    = 260;

  // Font columns, leftmost column in the top byte; bit n of a byte is row n.
  localparam logic [39:0] FONT_COLS [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  typedef struct {
    logic        is_cmd;
    logic [15:0] word;
    logic        last;
  } bus_write_t;

  // Tracks the text cursor and holds the bus writes still owed by the block.
  class cell_write_board;
    logic [15:0] cursor_x;
    logic [15:0] line_y;
    bit          stopped;
    bus_write_t  owed_writes[$];
    int          bad_writes;

    function new();
      cursor_x   = '0;
      line_y     = '0;
      stopped    = 1'b1;
      bad_writes = 0;
    endfunction

    function void owe(logic is_cmd, logic [15:0] word, logic last);
      bus_write_t w;
      w.is_cmd = is_cmd;
      w.word   = word;
      w.last   = last;
      owed_writes.push_back(w);
    endfunction

    function void owe_window(logic [7:0] cmd, logic [15:0] lo, logic [15:0] hi);
      owe(1'b1, {8'h00, cmd}, 1'b0);
      owe(1'b0, {8'h00, lo[15:8]}, 1'b0);
      owe(1'b0, {8'h00, lo[7:0]}, 1'b0);
      owe(1'b0, {8'h00, hi[15:8]}, 1'b0);
      owe(1'b0, {8'h00, hi[7:0]}, 1'b0);
    endfunction

    // Returns the number of bus writes the accepted character causes.
    function int take_char(logic [7:0] code, logic first, logic [15:0] sx,
                           logic [15:0] sy, logic [15:0] fg, logic [15:0] bg);
      logic [7:0]  c;
      logic [6:0]  glyph_idx;
      logic [39:0] glyph;
      logic [7:0]  col_bits;
      logic        pix;
      if (first) begin
        cursor_x = sx;
        line_y   = sy;
        stopped  = 1'b0;
      end
      if (stopped) return 0;
      c = (code < CODE_FIRST || code > CODE_LAST) ? CODE_REPLACE : code;
      glyph_idx = 7'(c - CODE_FIRST);
      glyph = FONT_COLS[glyph_idx];
      owe_window(CMD_COLUMN_SET, cursor_x, cursor_x + CELL_XSPAN);
      owe_window(CMD_ROW_SET, line_y, line_y + CELL_YSPAN);
      owe(1'b1, {8'h00, CMD_MEM_WRITE}, 1'b0);
      for (int row = 0; row < CELL_ROWS; row++) begin
        for (int col = 0; col < CELL_COLS; col++) begin
          pix = 1'b0;
          if (col < GLYPH_COLS) begin
            col_bits = glyph[39 - 8 * col -: 8];
            pix = col_bits[row];
          end
          owe(1'b0, pix ? fg : bg, (row == CELL_ROWS - 1 && col == CELL_COLS - 1));
        end
      end
      cursor_x = cursor_x + CELL_STEP;
      if (int'(cursor_x) + int'(CELL_STEP) > SCREEN_W) stopped = 1'b1;
      return 11 + CELL_ROWS * CELL_COLS;
    endfunction

    function void check_write(logic is_cmd, logic [15:0] word, logic last);
      bus_write_t w;
      if (owed_writes.size() == 0) begin
        bad_writes++;
        if (bad_writes <= REPORT_LIMIT)
          $display("unexpected write: cmd=%0b word=%h last=%0b", is_cmd, word, last);
        return;
      end
      w = owed_writes.pop_front();
      if (is_cmd !== w.is_cmd || word !== w.word || last !== w.last) begin
        bad_writes++;
        if (bad_writes <= REPORT_LIMIT)
          $display("write mismatch: expected cmd=%0b word=%h last=%0b, got cmd=%0b word=%h last=%0b",
                   w.is_cmd, w.word, w.last, is_cmd, word, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  cell_write_board board;
  int src_idle_pct = 14;
  int snk_idle_pct = 46;
  int sent_items   = 0;
  int quiet_cycles = 0;

  glyph_cell_text_renderer #(.SCREEN_WIDTH(SCREEN_W)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_write(m_tuser, m_tdata, m_tlast);
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[glyph_cell_text_renderer] ERROR");
        $finish;
      end
    end
  end

  // Called and returning at a falling edge; the character is noted when accepted.
  task automatic send_char(input logic [7:0] code, input logic first,
                           input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] fg, input logic [15:0] bg);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {bg, fg, sy, sx, code};
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    void'(board.take_char(code, first, sx, sy, fg, bg));
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_code();
    if ($urandom_range(99) < 85) return 8'($urandom_range(CODE_FIRST, CODE_LAST));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] rand_color();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // A string start at a chosen kind of position, its characters, and now and
  // then stray characters that extend the string or, once it has stopped, draw nothing.
  task automatic send_random_string();
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] fg;
    logic [15:0] bg;
    int          len;
    case ($urandom_range(9))
      0, 1, 2: sx = 16'($urandom_range(SCREEN_W - 6));
      3, 4:    sx = 16'($urandom_range(SCREEN_W - 24, SCREEN_W));
      5, 6:    sx = 16'($urandom_range(16'hFFFF));
      7:       sx = 16'($urandom_range(16'hFFF0, 16'hFFFF));
      default: sx = 16'($urandom_range(SCREEN_W + 12));
    endcase
    case ($urandom_range(5))
      0:       sy = 16'($urandom_range(16'hFFF6, 16'hFFFF));
      1:       sy = 16'($urandom_range(16'hFFFF));
      default: sy = 16'($urandom_range(240));
    endcase
    fg  = rand_color();
    bg  = rand_color();
    len = $urandom_range(1, 9);
    send_char(rand_code(), 1'b1, sx, sy, fg, bg);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(3) == 0) begin
        fg = rand_color();
        bg = rand_color();
      end
      // Position fields of a non-start character must be ignored.
      send_char(rand_code(), 1'b0, 16'($urandom_range(16'hFFFF)),
                16'($urandom_range(16'hFFFF)), fg, bg);
    end
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_char(8'($urandom_range(255)), 1'b0, 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)), rand_color(), rand_color());
      end
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Nothing is drawn before the first string start.
    send_char(8'h41, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_char(8'h41, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_char(CODE_FIRST, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_char(CODE_LAST, 1'b0, 16'hFFFF, 16'hFFFF, 16'hF800, 16'h07E0);
    // Codes outside the font fall back to the question mark.
    send_char(8'h1F, 1'b0, 16'h0000, 16'h0000, 16'h001F, 16'hFFE0);
    send_char(8'h7F, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_char(8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_char(8'hFF, 1'b0, 16'h0000, 16'h0000, 16'hAAAA, 16'h5555);
    send_char(CODE_REPLACE, 1'b0, 16'h0000, 16'h0000, 16'h5555, 16'hAAAA);
    // Near the right edge: one more cell fits, then the string stops.
    send_char(8'h30, 1'b1, 16'(SCREEN_W - 12), 16'd100, 16'h1234, 16'hEDCB);
    send_char(8'h5A, 1'b0, 16'h0000, 16'h0000, 16'h1234, 16'hEDCB);
    send_char(8'h7A, 1'b0, 16'h0000, 16'h0000, 16'h1234, 16'hEDCB);
    // A start beyond the screen draws its first character only.
    send_char(8'h4D, 1'b1, 16'd1000, 16'hFFFC, 16'hFFFF, 16'h0000);
    send_char(8'h4E, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    // Window edges and the cursor wrap around the top of the 16-bit range.
    send_char(8'h80, 1'b1, 16'hFFFF, 16'hFFFF, 16'h8001, 16'h7FFE);
    send_char(8'h57, 1'b0, 16'h0000, 16'h0000, 16'h8001, 16'h7FFE);
    send_char(CODE_LAST, 1'b1, 16'hFFFA, 16'hFFF8, 16'h0F0F, 16'hF0F0);
    send_char(8'h21, 1'b0, 16'h0000, 16'h0000, 16'h0F0F, 16'hF0F0);
    send_char(8'h23, 1'b1, 16'(SCREEN_W - 6), 16'd0, 16'hFFFF, 16'hFFFF);
    send_char(8'h24, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    // A new string start while the previous one is still running.
    send_char(8'h61, 1'b1, 16'd7, 16'd3, 16'hA5A5, 16'hA5A5);
    send_char(8'h62, 1'b1, 16'd200, 16'd50, 16'h0000, 16'h0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 14;
          snk_idle_pct = 46;
        end
        1: begin
          src_idle_pct = 46;
          snk_idle_pct = 14;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      while (sent_items < ITEM_TARGET * (phase + 1) / 3) send_random_string();
    end
    s_tvalid <= 1'b0;

    while (board.owed_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.bad_writes == 0 && board.owed_writes.size() == 0) begin
      $display("[glyph_cell_text_renderer] OK");
    end else begin
      $display("[glyph_cell_text_renderer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
